/* rtl/dmcr_pkg.sv */
// ----------------------------------------------------------------------------
// dmcr_pkg
// Shared sizes, field widths and types of the direct-mapped read cache.
// ----------------------------------------------------------------------------
package dmcr_pkg;

    localparam int NUM_LINES    = 4;
    localparam int LINE_BYTES   = 8;
    localparam int MEM_BYTES    = 1024;

    localparam int ADDR_W       = 10;
    localparam int BYTE_W       = 8;
    localparam int MISS_W       = 16;
    localparam int TIME_W       = 32;

    localparam int WORD_W       = $clog2(LINE_BYTES);
    localparam int LINE_W       = $clog2(NUM_LINES);
    localparam int TAG_W        = ADDR_W - WORD_W - LINE_W;
    localparam int MEM_AW       = $clog2(MEM_BYTES);
    localparam int LRAM_DEPTH   = NUM_LINES * LINE_BYTES;
    localparam int LRAM_AW      = LINE_W + WORD_W;
    localparam int CNT_W        = WORD_W + 1;

    localparam int MISS_PENALTY = 10;

    // Command to the shared counter unit
    typedef struct packed {
        logic add_en;     // add to the time counter
        logic penalty;    // 1: add the miss penalty, 0: add one
        logic miss_inc;   // count one miss
    } acc_cmd_t;

endpackage

/* rtl/dmcr_ram.sv */
// ----------------------------------------------------------------------------
// dmcr_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmcr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dmcr_acc.sv */
// ----------------------------------------------------------------------------
// dmcr_acc
// Saturating time accumulator and miss counter, one shared time adder.
// ----------------------------------------------------------------------------
module dmcr_acc
    import dmcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  acc_cmd_t          cmd,
    output logic [TIME_W-1:0] elapsed_time,
    output logic [MISS_W-1:0] miss_count
);

    logic [TIME_W-1:0] time_reg, time_next;
    logic [MISS_W-1:0] miss_reg, miss_next;
    logic [TIME_W-1:0] amount;
    logic [TIME_W:0]   sum;

    // One adder serves both the per-access tick and the miss penalty
    assign amount = cmd.penalty ? TIME_W'(MISS_PENALTY) : TIME_W'(1);
    assign sum    = {1'b0, time_reg} + {1'b0, amount};

    always_comb
    begin
        time_next = time_reg;
        miss_next = miss_reg;
        if (cmd.add_en)
        begin
            time_next = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
        if (cmd.miss_inc && (miss_reg != '1))
        begin
            miss_next = miss_reg + MISS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            miss_reg <= '0;
        end
        else
        begin
            time_reg <= time_next;
            miss_reg <= miss_next;
        end
    end

    assign elapsed_time = time_reg;
    assign miss_count   = miss_reg;

endmodule

/* rtl/direct_mapped_cache_read.sv */
// ----------------------------------------------------------------------------
// direct_mapped_cache_read
// Direct-mapped read cache, 4 lines of 8 bytes, over a 1024-byte memory.
// ----------------------------------------------------------------------------
// A load transaction (tuser = 0) writes one byte of backing memory. A read
// transaction (tuser = 1) looks up the line picked by address[4:3] and
// compares address[9:5] against the stored tag. A hit goes through lookup,
// line-store read and result; a miss first fills the line, streaming the 8
// bytes of the aligned block one per cycle through the single read port of
// the backing memory, whose read port is registered. Each read returns one
// result transaction carrying the byte, a hit flag, the saturating miss
// count and the saturating elapsed time (1 per read, 10 more per miss). The
// input side is busy while a read is in progress; a finished result waits in
// an output register, so the next transaction is taken while it is still
// unread. If the previous result is still unread when the next read reaches
// its result step, that step holds while the master side applies
// back-pressure.
// Backing memory is not cleared: reading a byte never loaded is undefined.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read
    import dmcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[9:0], load_byte[17:10], zero pad
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // read_byte[7:0], miss_count[23:8],
                                   // elapsed_time[55:24]
    output logic [0:0]  m_tuser    // hit[0]
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_READ   = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Input fields
    logic              in_req_type;
    logic [ADDR_W-1:0] in_address;
    logic [BYTE_W-1:0] in_load_byte;
    logic              in_xfer;

    assign in_req_type  = s_tuser[0];
    assign in_address   = s_tdata[ADDR_W-1:0];
    assign in_load_byte = s_tdata[ADDR_W +: BYTE_W];
    assign in_xfer      = s_tvalid && s_tready;

    // Request and tag state
    logic [ADDR_W-1:0] addr_reg;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [TAG_W-1:0]  line_tag_reg [NUM_LINES];
    logic [NUM_LINES-1:0] line_valid_reg;

    logic [WORD_W-1:0] req_word;
    logic [LINE_W-1:0] req_line;
    logic [TAG_W-1:0]  req_tag;
    logic              lookup_hit;
    logic              fill_done;
    logic [CNT_W-1:0]  fill_wr_cnt;

    assign req_word   = addr_reg[WORD_W-1:0];
    assign req_line   = addr_reg[WORD_W +: LINE_W];
    assign req_tag    = addr_reg[ADDR_W-1 -: TAG_W];
    assign lookup_hit = line_valid_reg[req_line] && (line_tag_reg[req_line] == req_tag);
    assign fill_done  = (fill_cnt_reg == CNT_W'(LINE_BYTES));
    assign fill_wr_cnt = fill_cnt_reg - CNT_W'(1);

    // Output register
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [MISS_W-1:0] out_miss_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_free;
    logic              out_load;

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Backing memory
    logic              bm_wr_en;
    logic              bm_rd_en;
    logic [MEM_AW-1:0] bm_rd_addr;
    logic [BYTE_W-1:0] bm_rd_data;

    assign bm_wr_en   = in_xfer && !in_req_type;
    assign bm_rd_en   = (state_reg == ST_FILL) && !fill_done;
    assign bm_rd_addr = {addr_reg[MEM_AW-1:WORD_W], fill_cnt_reg[WORD_W-1:0]};

    dmcr_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (MEM_BYTES)
    ) u_backing_mem (
        .clk     (clk),
        .wr_en   (bm_wr_en),
        .wr_addr (in_address[MEM_AW-1:0]),
        .wr_data (in_load_byte),
        .rd_en   (bm_rd_en),
        .rd_addr (bm_rd_addr),
        .rd_data (bm_rd_data)
    );

    // Line store: written one byte per cycle during a fill; each byte is written
    // in the cycle after its backing memory read
    logic               ls_wr_en;
    logic [LRAM_AW-1:0] ls_wr_addr;
    logic               ls_rd_en;
    logic [BYTE_W-1:0]  ls_rd_data;

    assign ls_wr_en   = (state_reg == ST_FILL) && (fill_cnt_reg != '0);
    assign ls_wr_addr = {req_line, fill_wr_cnt[WORD_W-1:0]};
    assign ls_rd_en   = (state_reg == ST_READ);

    dmcr_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (LRAM_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (ls_wr_addr),
        .wr_data (bm_rd_data),
        .rd_en   (ls_rd_en),
        .rd_addr ({req_line, req_word}),
        .rd_data (ls_rd_data)
    );

    // Shared counter unit: +1 in lookup, +10 and miss count at fill end
    acc_cmd_t          acc_cmd;
    logic [TIME_W-1:0] acc_time;
    logic [MISS_W-1:0] acc_miss;

    always_comb
    begin
        acc_cmd = '0;
        if (state_reg == ST_LOOKUP)
        begin
            acc_cmd.add_en = 1'b1;
        end
        else if ((state_reg == ST_FILL) && fill_done)
        begin
            acc_cmd.add_en   = 1'b1;
            acc_cmd.penalty  = 1'b1;
            acc_cmd.miss_inc = 1'b1;
        end
    end

    dmcr_acc u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (acc_cmd),
        .elapsed_time (acc_time),
        .miss_count   (acc_miss)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        hit_next      = hit_reg;
        fill_cnt_next = fill_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_req_type)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                hit_next      = lookup_hit;
                fill_cnt_next = '0;
                state_next    = lookup_hit ? ST_READ : ST_FILL;
            end
            ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hit_reg        <= 1'b0;
            fill_cnt_reg   <= '0;
            line_valid_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                line_tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            hit_reg      <= hit_next;
            fill_cnt_reg <= fill_cnt_next;
            if ((state_reg == ST_FILL) && fill_done)
            begin
                line_tag_reg[req_line]   <= req_tag;
                line_valid_reg[req_line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            addr_reg <= in_address;
        end
        if (out_load)
        begin
            out_hit_reg  <= hit_reg;
            out_byte_reg <= ls_rd_data;
            out_miss_reg <= acc_miss;
            out_time_reg <= acc_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_time_reg, out_miss_reg, out_byte_reg};
    assign m_tuser  = out_hit_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_read_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_req_type) |=> (state_reg == ST_LOOKUP))
        else $error("read transaction did not start a lookup");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !in_req_type) |=> (state_reg == ST_IDLE))
        else $error("load transaction left the idle state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_cnt_reg <= CNT_W'(LINE_BYTES)))
        else $error("fill counter ran past the line size");

    a_fill_installs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) && fill_done) |=>
            (line_valid_reg[$past(req_line)] && (state_reg == ST_READ)))
        else $error("line fill did not install a valid line");

    a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (acc_miss >= $past(acc_miss)))
        else $error("miss counter went backwards");

endmodule
